[hw/rtl/pst_pkg.sv]
// ----------------------------------------------------------------------------
// Pedal step tachometer package
// Field widths, register indexes, reset values and default parameters.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

  localparam int unsigned PERIOD_W   = 8;
  localparam int unsigned MIN_W      = 16;
  localparam int unsigned RPM_W      = 16;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned DEF_INTERVAL_WIDTH = 16;
  localparam int unsigned DEF_LEVEL_WIDTH    = 8;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd30;
  localparam logic [MIN_W-1:0]    MIN_RESET    = 16'd200;
  localparam logic [RPM_W-1:0]    RPM_NUM      = 16'd60000;

  // Configuration register indexes
  localparam logic CFG_PERIOD = 1'b0;
  localparam logic CFG_MIN    = 1'b1;

  // Result word: step_seen, step_total, speed_rpm, peak_rpm, zero pad
  localparam int unsigned OUT_BITS = 1 + TOTAL_W + 2 * RPM_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

[hw/rtl/pedal_step_tachometer.sv]
// ----------------------------------------------------------------------------
// Pedal step tachometer
// Counts pedal steps from hall sensor samples and derives speed in rpm.
// ----------------------------------------------------------------------------
// One sample is taken per request on the slave stream; one result follows on
// the master stream. A clear or priming sample goes from the accept state
// straight to the emit state. Other samples run a bit-serial multiply of
// interval count by sample period, one period bit at a time, a compare state,
// and on a step a restoring divide of 60000 by the elapsed time, one quotient
// bit at a time, then the emit state, which waits for the output register to
// free up. A new request is taken while a result still waits downstream.
// Configuration writes take effect at once and are meant for idle periods
// only.
`default_nettype none

module pedal_step_tachometer import pst_pkg::*; #(
  parameter int unsigned INTERVAL_WIDTH = DEF_INTERVAL_WIDTH,
  parameter int unsigned LEVEL_WIDTH    = DEF_LEVEL_WIDTH,
  localparam int unsigned IN_W          = ((LEVEL_WIDTH + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // sample stream
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [IN_W-1:0]       s_axis_tdata_i,  // sensor_level
  input  wire logic                  s_axis_tuser_i,  // clear_stats
  // result stream
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // step_seen, step_total, speed_rpm, peak_rpm, zero pad
  output logic [OUT_W-1:0]           m_axis_tdata_o
);

  localparam int unsigned EW   = INTERVAL_WIDTH + PERIOD_W;
  localparam int unsigned CW   = (EW > RPM_W + 1) ? EW : RPM_W + 1;
  localparam int unsigned MCW  = $clog2(PERIOD_W);
  localparam int unsigned DCW  = $clog2(RPM_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                    state_q;
  logic [PERIOD_W-1:0]       period_q;
  logic [MIN_W-1:0]          min_q;
  logic [LEVEL_WIDTH-1:0]    last_level_q;
  logic [LEVEL_WIDTH-1:0]    level_q;
  logic                      primed_q;
  logic [INTERVAL_WIDTH-1:0] count_q;
  logic [TOTAL_W-1:0]        total_q;
  logic [RPM_W-1:0]          rpm_q;
  logic [RPM_W-1:0]          peak_q;
  logic                      step_q;

  // serial datapath
  logic [EW-1:0]             acc_q;
  logic [EW-1:0]             mcand_q;
  logic [PERIOD_W-1:0]       mplier_q;
  logic [MCW-1:0]            mcnt_q;
  logic [RPM_W-1:0]          rem_q;
  logic [RPM_W-1:0]          dvd_q;
  logic [RPM_W-1:0]          quo_q;
  logic [DCW-1:0]            dcnt_q;

  // output register
  logic                      out_vld_q;
  logic                      o_step_q;
  logic [TOTAL_W-1:0]        o_total_q;
  logic [RPM_W-1:0]          o_rpm_q;
  logic [RPM_W-1:0]          o_peak_q;

  logic                      in_acc;
  logic                      out_free;
  logic [EW-1:0]             acc_add;
  logic [RPM_W:0]            rem_sh;
  logic [CW-1:0]             rem_ext;
  logic [CW-1:0]             div_ext;
  logic [CW-1:0]             rem_diff;
  logic                      rem_ge;
  logic [RPM_W-1:0]          quo_next;
  logic                      is_step;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_W'({o_peak_q, o_rpm_q, o_total_q, o_step_q});

  always_comb begin
    acc_add  = mplier_q[0] ? (acc_q + mcand_q) : acc_q;
    rem_sh   = {rem_q, dvd_q[RPM_W-1]};
    rem_ext  = CW'(rem_sh);
    div_ext  = CW'(acc_q);
    rem_ge   = (rem_ext >= div_ext);
    rem_diff = rem_ext - div_ext;
    quo_next = {quo_q[RPM_W-2:0], rem_ge};
    is_step  = (level_q < last_level_q) && (acc_q > EW'(min_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      period_q     <= PERIOD_RESET;
      min_q        <= MIN_RESET;
      last_level_q <= '0;
      level_q      <= '0;
      primed_q     <= 1'b0;
      count_q      <= '0;
      total_q      <= '0;
      rpm_q        <= '0;
      peak_q       <= '0;
      step_q       <= 1'b0;
      acc_q        <= '0;
      mcand_q      <= '0;
      mplier_q     <= '0;
      mcnt_q       <= '0;
      rem_q        <= '0;
      dvd_q        <= '0;
      quo_q        <= '0;
      dcnt_q       <= '0;
      out_vld_q    <= 1'b0;
      o_step_q     <= 1'b0;
      o_total_q    <= '0;
      o_rpm_q      <= '0;
      o_peak_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
          CFG_MIN:    min_q    <= cfg_data_i[MIN_W-1:0];
          default: ;
        endcase
      end

      if (state_q == ST_EMIT && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            step_q  <= 1'b0;
            level_q <= s_axis_tdata_i[LEVEL_WIDTH-1:0];
            if (s_axis_tuser_i) begin
              last_level_q <= '0;
              primed_q     <= 1'b0;
              count_q      <= '0;
              total_q      <= '0;
              rpm_q        <= '0;
              peak_q       <= '0;
              state_q      <= ST_EMIT;
            end else if (!primed_q) begin
              last_level_q <= s_axis_tdata_i[LEVEL_WIDTH-1:0];
              primed_q     <= 1'b1;
              count_q      <= '0;
              state_q      <= ST_EMIT;
            end else begin
              acc_q    <= '0;
              mcand_q  <= EW'(count_q);
              mplier_q <= period_q;
              mcnt_q   <= '0;
              state_q  <= ST_MUL;
            end
          end
        end

        // shift-add, one period bit per cycle
        ST_MUL: begin
          acc_q    <= acc_add;
          mcand_q  <= {mcand_q[EW-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[PERIOD_W-1:1]};
          mcnt_q   <= mcnt_q + 1'b1;
          if (mcnt_q == MCW'(PERIOD_W - 1)) begin
            state_q <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          last_level_q <= level_q;
          if (is_step) begin
            rem_q   <= '0;
            dvd_q   <= RPM_NUM;
            quo_q   <= '0;
            dcnt_q  <= '0;
            state_q <= ST_DIV;
          end else begin
            if (count_q != {INTERVAL_WIDTH{1'b1}}) begin
              count_q <= count_q + 1'b1;
            end
            state_q <= ST_EMIT;
          end
        end

        // restoring divide, one quotient bit per cycle
        ST_DIV: begin
          rem_q  <= rem_ge ? rem_diff[RPM_W-1:0] : rem_sh[RPM_W-1:0];
          dvd_q  <= {dvd_q[RPM_W-2:0], 1'b0};
          quo_q  <= quo_next;
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DCW'(RPM_W - 1)) begin
            rpm_q   <= quo_next;
            if (quo_next > peak_q) begin
              peak_q <= quo_next;
            end
            total_q <= total_q + 1'b1;
            count_q <= '0;
            step_q  <= 1'b1;
            state_q <= ST_EMIT;
          end
        end

        // hold until the output register frees up
        ST_EMIT: begin
          if (out_free) begin
            o_step_q  <= step_q;
            o_total_q <= total_q;
            o_rpm_q   <= rpm_q;
            o_peak_q  <= peak_q;
            state_q   <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
